[sv/midi_merge_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi merger package
// Types, codes and byte classification for the two-port MIDI merger.
// ----------------------------------------------------------------------------
package midi_merge_pkg;

    localparam int FIFO_DEPTH = 32;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] SYSEX_END_BYTE = 8'hF7;
    localparam logic [7:0] REALTIME_FIRST = 8'hF8;

    typedef enum logic [1:0] {
        KIND_P1_BYTE = 2'd0,
        KIND_P2_BYTE = 2'd1,
        KIND_P1_DONE = 2'd2,
        KIND_P2_DONE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OWN_IDLE = 2'd0,
        OWN_P1   = 2'd1,
        OWN_P2   = 2'd2
    } owner_t;

    typedef enum logic [2:0] {
        MARK_NONE        = 3'd0,
        MARK_CHAN1       = 3'd1,
        MARK_CHAN2       = 3'd2,
        MARK_CH1_STOPPED = 3'd3,
        MARK_CH2_STOPPED = 3'd4
    } mark_t;

    typedef enum logic [1:0] {
        CLS_PLAIN     = 2'd0,
        CLS_REALTIME  = 2'd1,
        CLS_SYSEX_END = 2'd2
    } byte_cls_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_DRAIN = 1'b1
    } state_t;

    function automatic byte_cls_t byte_class(input logic [7:0] b);
        byte_cls_t cls;
        if (b == SYSEX_END_BYTE)
            cls = CLS_SYSEX_END;
        else if (b >= REALTIME_FIRST)
            cls = CLS_REALTIME;
        else
            cls = CLS_PLAIN;
        return cls;
    endfunction

endpackage

[sv/midi_two_port_merger_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi two port merger
// Merges two MIDI byte streams onto one output, holding the non-owning
// port's bytes in a byte FIFO until a done or sysex end event drains it.
// ----------------------------------------------------------------------------
// An item that emits at most its own byte does not stall the input, and the
// next item is taken as soon as the output register is free. An item that
// drains the FIFO keeps the input stalled until every waiting byte, up to
// FIFO_DEPTH of them, has been sent, and longer while the output is stalled.
// This is set by the single read port of the FIFO memory, which sends one byte
// per cycle through the output register while the output is not stalled. No
// clearing pass after reset.
module midi_two_port_merger_top
    import midi_merge_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] kind,
    input  logic [7:0] midi_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    state_t             state_reg, state_next;
    owner_t             owner_reg, owner_next;
    mark_t              mark_reg, mark_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               last_reg, last_next;
    logic [7:0]         rd_data_reg;
    logic [7:0]         fifo_mem [FIFO_DEPTH];

    logic               accept;
    logic               out_free;
    logic               do_push;
    logic               drain_load;
    byte_cls_t          cls;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign cls      = byte_class(midi_byte);

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FIFO_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            owner_reg     <= OWN_IDLE;
            mark_reg      <= MARK_NONE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            owner_reg     <= owner_next;
            mark_reg      <= mark_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

    // read follows the next read pointer so the head byte is always ready
    always_ff @(posedge clk)
    begin
        if (do_push)
            fifo_mem[wr_ptr_reg] <= midi_byte;
        rd_data_reg <= fifo_mem[rd_ptr_next];
    end

    always_comb
    begin
        logic emit_in;
        logic start_drain;
        logic want_push;

        emit_in     = 1'b0;
        start_drain = 1'b0;
        want_push   = 1'b0;

        state_next     = state_reg;
        owner_next     = owner_reg;
        mark_next      = mark_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        do_push        = 1'b0;
        drain_load     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind_t'(kind))
                        KIND_P1_BYTE:
                        begin
                            if (cls != CLS_PLAIN)
                                emit_in = 1'b1;
                            else if (owner_reg == OWN_P2)
                            begin
                                mark_next = MARK_CHAN2;
                                want_push = 1'b1;
                            end
                            else
                            begin
                                owner_next = OWN_P1;
                                emit_in    = 1'b1;
                            end
                        end
                        KIND_P2_BYTE:
                        begin
                            if (cls == CLS_REALTIME)
                                emit_in = 1'b1;
                            else if (owner_reg == OWN_P1)
                            begin
                                if (cls != CLS_SYSEX_END)
                                    mark_next = MARK_CHAN1;
                                want_push = 1'b1;
                            end
                            else if (cls == CLS_SYSEX_END)
                            begin
                                emit_in     = 1'b1;
                                start_drain = (cnt_reg != '0);
                                owner_next  = OWN_P1;
                            end
                            else
                            begin
                                owner_next = OWN_P2;
                                emit_in    = 1'b1;
                            end
                        end
                        KIND_P1_DONE:
                        begin
                            if (owner_reg == OWN_P1)
                            begin
                                if (cnt_reg != '0)
                                begin
                                    start_drain = 1'b1;
                                    if (mark_reg == MARK_CHAN2)
                                        owner_next = OWN_P2;
                                    else if (mark_reg == MARK_CH2_STOPPED)
                                        owner_next = OWN_IDLE;
                                end
                                else
                                    owner_next = OWN_IDLE;
                            end
                            else if (mark_reg == MARK_CHAN1)
                                mark_next = MARK_CH1_STOPPED;
                        end
                        KIND_P2_DONE:
                        begin
                            if (owner_reg == OWN_P2)
                            begin
                                if (cnt_reg != '0)
                                begin
                                    start_drain = 1'b1;
                                    owner_next  = OWN_P1;
                                end
                                else
                                    owner_next = OWN_IDLE;
                            end
                        end
                        default:
                        begin
                            emit_in = 1'b0;
                        end
                    endcase

                    // full fifo drops the byte
                    if (want_push && (cnt_reg != CNT_W'(FIFO_DEPTH)))
                    begin
                        do_push     = 1'b1;
                        wr_ptr_next = ptr_inc(wr_ptr_reg);
                        cnt_next    = cnt_reg + 1'b1;
                    end

                    if (emit_in)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = midi_byte;
                        last_next      = !start_drain;
                    end

                    if (start_drain)
                        state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    drain_load     = 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = rd_data_reg;
                    last_next      = (cnt_reg == CNT_W'(1));
                    rd_ptr_next    = ptr_inc(rd_ptr_reg);
                    cnt_next       = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(FIFO_DEPTH))
        else $error("fifo count above depth");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> cnt_reg != '0)
        else $error("drain with empty fifo");

    a_drain_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        drain_load && cnt_reg == CNT_W'(1) |=> state_reg == ST_IDLE && last_reg)
        else $error("drain did not end on last byte");

    a_no_push_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DRAIN |-> !do_push)
        else $error("fifo write during drain");
`endif

endmodule
